// File: hw/rtl/cpd_pkg.sv
// ----------------------------------------------------------------------------
// cpd_pkg
// Types and codes shared by the circular piece deque unit and its checker.
// ----------------------------------------------------------------------------
package cpd_pkg;

  localparam int unsigned PieceW = 8;

  typedef enum logic [2:0] {
    FUNC_APPEND = 3'd0,
    FUNC_HEAD   = 3'd1,
    FUNC_REMOVE = 3'd2,
    FUNC_ROTATE = 3'd3,
    FUNC_CLEAR  = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_ROT
  } state_e;

  typedef struct packed {
    logic [2:0] func;
    logic [3:0] color;
    logic [3:0] shape;
  } req_t;

  typedef struct packed {
    logic [4:0] count;
    logic [3:0] front_color;
    logic [3:0] front_shape;
    logic [1:0] status;
  } rsp_t;

endpackage

// File: hw/rtl/circular_piece_deque_unit.sv
// ----------------------------------------------------------------------------
// circular_piece_deque_unit
// Ordered circular sequence of up to CAPACITY pieces held in one RAM.
// ----------------------------------------------------------------------------
// Append, head insert, clear and unused codes complete at once: an accepted
// command shows its result with done_o in the next cycle, and busy stays
// low so a new command can follow at once. Rotate of two or more pieces
// passes through S_ROT for the RAM read of the new head piece; with fewer
// pieces it completes at once. Remove walks the sequence from the head
// through the single RAM read port, one entry per cycle, and on a match
// then moves each later entry one place forward, one per cycle; on an
// empty sequence it ends at once with a miss. The result is presented for
// exactly one cycle and must be taken then.
// ----------------------------------------------------------------------------
module circular_piece_deque_unit
  import cpd_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW:0]   CapWide = (CW + 1)'(CAPACITY);
  localparam logic [CW-1:0] CapCnt  = CW'(CAPACITY);
  localparam logic [AW-1:0] LastPos = AW'(CAPACITY - 1);

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [CW:0] sum;
    logic [CW:0] wrapped;
    sum     = (CW + 1)'(base) + (CW + 1)'(off);
    wrapped = (sum >= CapWide) ? (sum - CapWide) : sum;
    return wrapped[AW-1:0];
  endfunction

  state_e              state_q, state_d;
  logic [AW-1:0]       head_q, head_d;
  logic [CW-1:0]       count_q, count_d;
  logic [PieceW-1:0]   front_q, front_d;
  logic [CW-1:0]       idx_q, idx_d;
  logic [PieceW-1:0]   piece_q, piece_d;
  rsp_t                rsp_q, rsp_d;
  logic                done_q, done_d;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [PieceW-1:0]   ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [PieceW-1:0]   ram_rdata;

  logic                accept;
  logic [PieceW-1:0]   piece_in;
  logic [CW-1:0]       idx_inc;
  logic                last;
  logic                full;
  logic                fin;
  status_e             fin_status;
  logic [AW-1:0]       pos;
  logic [CW+4:0]       count_ext;
  logic [PieceW-1:0]   front_out;

  cpd_ram #(
    .Width(PieceW),
    .Depth(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign busy     = (state_q != S_IDLE);
  assign accept   = start && !busy;
  assign piece_in = {req_i.color, req_i.shape};
  assign idx_inc  = idx_q + CW'(1);
  assign last     = (idx_inc == count_q);
  assign full     = (count_q == CapCnt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q <= front_d;
    idx_q   <= idx_d;
    piece_q <= piece_d;
    rsp_q   <= rsp_d;
  end

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    count_d    = count_q;
    front_d    = front_q;
    idx_d      = idx_q;
    piece_d    = piece_q;
    rsp_d      = rsp_q;
    done_d     = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = slot(head_q, count_q);
    ram_wdata  = piece_in;
    ram_raddr  = slot(head_q, idx_inc);
    fin        = 1'b0;
    fin_status = ST_DONE;
    pos        = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          piece_d = piece_in;
          case (req_i.func)
            FUNC_APPEND: begin
              fin = 1'b1;
              if (full) begin
                fin_status = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = slot(head_q, count_q);
                count_d   = count_q + CW'(1);
                if (count_q == '0) begin
                  front_d = piece_in;
                end
              end
            end
            FUNC_HEAD: begin
              fin = 1'b1;
              if (full) begin
                fin_status = ST_FULL;
              end else begin
                pos       = (head_q == '0) ? LastPos : (head_q - AW'(1));
                ram_we    = 1'b1;
                ram_waddr = pos;
                head_d    = pos;
                front_d   = piece_in;
                count_d   = count_q + CW'(1);
              end
            end
            FUNC_REMOVE: begin
              if (count_q == '0) begin
                fin        = 1'b1;
                fin_status = ST_MISS;
              end else begin
                ram_raddr = head_q;
                idx_d     = '0;
                state_d   = S_SCAN;
              end
            end
            FUNC_ROTATE: begin
              if (count_q >= CW'(2)) begin
                // old head goes to the tail; fetch the new head
                pos       = slot(head_q, CW'(1));
                ram_we    = !full;
                ram_waddr = slot(head_q, count_q);
                ram_wdata = front_q;
                head_d    = pos;
                ram_raddr = pos;
                state_d   = S_ROT;
              end else begin
                fin = 1'b1;
              end
            end
            FUNC_CLEAR: begin
              fin     = 1'b1;
              count_d = '0;
              head_d  = '0;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_ROT: begin
        front_d = ram_rdata;
        fin     = 1'b1;
        state_d = S_IDLE;
      end
      S_SCAN: begin
        if (ram_rdata == piece_q) begin
          if (last) begin
            count_d = count_q - CW'(1);
            fin     = 1'b1;
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_inc;
            state_d = S_SHIFT;
          end
        end else if (last) begin
          fin        = 1'b1;
          fin_status = ST_MISS;
          state_d    = S_IDLE;
        end else begin
          idx_d = idx_inc;
        end
      end
      S_SHIFT: begin
        // close the gap: move this entry one place toward the head
        ram_we    = 1'b1;
        ram_waddr = slot(head_q, idx_q - CW'(1));
        ram_wdata = ram_rdata;
        if (idx_q == CW'(1)) begin
          front_d = ram_rdata;
        end
        if (last) begin
          count_d = count_q - CW'(1);
          fin     = 1'b1;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_inc;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    count_ext = {5'b0, count_d};
    front_out = (count_d == '0) ? '0 : front_d;
    if (fin) begin
      done_d            = 1'b1;
      rsp_d.count       = count_ext[4:0];
      rsp_d.front_color = front_out[7:4];
      rsp_d.front_shape = front_out[3:0];
      rsp_d.status      = fin_status;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// File: hw/rtl/cpd_ram.sv
// ----------------------------------------------------------------------------
// cpd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cpd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/cpd_checker.sv
// ----------------------------------------------------------------------------
// cpd_checker
// Port-level checks of the circular piece deque unit, bound to the top level.
// ----------------------------------------------------------------------------
module cpd_checker
  import cpd_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input req_t req_i,
  input logic done_o,
  input rsp_t rsp_o
);

  logic quick_op;

  assign quick_op = (req_i.func == FUNC_APPEND) || (req_i.func == FUNC_HEAD) ||
                    (req_i.func == FUNC_CLEAR);

  a_empty_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (rsp_o.count == 5'd0) |-> (rsp_o.front_color == 4'd0) &&
                                        (rsp_o.front_shape == 4'd0))
    else $error("front piece not zero on empty store");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (CAPACITY >= 32) || (int'(rsp_o.count) <= CAPACITY))
    else $error("count above capacity");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (rsp_o.status == ST_FULL) |-> (rsp_o.count == 5'(CAPACITY)))
    else $error("insert dropped while not full");

  a_quick_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && quick_op |=> done_o && !busy)
    else $error("single-cycle command did not complete");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (req_i.func == FUNC_CLEAR) |=>
      (rsp_o.count == 5'd0) && (rsp_o.status == ST_DONE))
    else $error("clear did not empty the store");

endmodule

bind circular_piece_deque_unit cpd_checker #(
  .CAPACITY(CAPACITY)
) u_cpd_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .start (start),
  .busy  (busy),
  .req_i (req_i),
  .done_o(done_o),
  .rsp_o (rsp_o)
);

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for circular_piece_deque_unit. A shadow deque in the
// bench predicts count, front piece and status for every accepted command.
// Each done_o transfer is checked against the oldest prediction. Directed
// corner cases come first, then insert-heavy and remove-heavy random phases.
// The sender issues commands in random bursts and pauses after each random
// phase until the block has drained.
// ----------------------------------------------------------------------------
module testbench;
  import cpd_pkg::*;

  localparam int unsigned Capacity    = 16;
  localparam int          ClkPeriod   = 10;
  localparam int          ResetCycles = 8;
  localparam int          DrainCycles = 2 * Capacity + 4;
  localparam int          CycleLimit  = 200000;
  localparam int          ReportLimit = 10;
  localparam logic [2:0]  FuncSpareLo = 3'd5;
  localparam logic [2:0]  FuncSpareHi = 3'd7;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic done_o;
  rsp_t rsp_o;

  logic [7:0] shadow_store [Capacity];
  int         shadow_head;
  int         shadow_count;
  rsp_t       expected_rsp [$];
  rsp_t       want_rsp;
  int         fault_count = 0;
  int         cycle_count = 0;
  int         burst_left;

  circular_piece_deque_unit #(
    .CAPACITY(Capacity)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  function automatic int slot(int offset);
    return (shadow_head + offset) % Capacity;
  endfunction

  function automatic rsp_t deque_predict(req_t cmd);
    logic [7:0] piece;
    logic [7:0] front;
    rsp_t       rsp;
    int         hit;
    piece      = {cmd.color, cmd.shape};
    rsp.status = ST_DONE;
    case (cmd.func)
      FUNC_APPEND: begin
        if (shadow_count >= Capacity) begin
          rsp.status = ST_FULL;
        end else begin
          shadow_store[slot(shadow_count)] = piece;
          shadow_count++;
        end
      end
      FUNC_HEAD: begin
        if (shadow_count >= Capacity) begin
          rsp.status = ST_FULL;
        end else begin
          shadow_head = (shadow_head + Capacity - 1) % Capacity;
          shadow_store[shadow_head] = piece;
          shadow_count++;
        end
      end
      FUNC_REMOVE: begin
        hit = -1;
        for (int i = 0; i < shadow_count; i++) begin
          if (hit < 0 && shadow_store[slot(i)] == piece) hit = i;
        end
        if (hit < 0) begin
          rsp.status = ST_MISS;
        end else begin
          for (int i = hit; i + 1 < shadow_count; i++) begin
            shadow_store[slot(i)] = shadow_store[slot(i + 1)];
          end
          shadow_count--;
        end
      end
      FUNC_ROTATE: begin
        if (shadow_count >= 2) begin
          front = shadow_store[shadow_head];
          if (shadow_count < Capacity) shadow_store[slot(shadow_count)] = front;
          shadow_head = (shadow_head + 1) % Capacity;
        end
      end
      FUNC_CLEAR: begin
        shadow_count = 0;
        shadow_head  = 0;
      end
      default: ;
    endcase
    front           = (shadow_count > 0) ? shadow_store[shadow_head] : 8'h00;
    rsp.count       = 5'(shadow_count);
    rsp.front_color = front[7:4];
    rsp.front_shape = front[3:0];
    return rsp;
  endfunction

  function automatic req_t random_command(bit grow);
    req_t cmd;
    int   r;
    int   idx;
    r         = $urandom_range(0, 99);
    cmd.color = $urandom_range(0, 1) ? 4'($urandom_range(0, 1)) : 4'($urandom);
    cmd.shape = $urandom_range(0, 1) ? 4'($urandom_range(0, 1)) : 4'($urandom);
    if (r < (grow ? 35 : 15)) begin
      cmd.func = FUNC_APPEND;
    end else if (r < (grow ? 60 : 25)) begin
      cmd.func = FUNC_HEAD;
    end else if (r < (grow ? 80 : 78)) begin
      cmd.func = FUNC_REMOVE;
      if (shadow_count > 0 && $urandom_range(0, 3) != 0) begin
        idx                    = $urandom_range(0, shadow_count - 1);
        {cmd.color, cmd.shape} = shadow_store[slot(idx)];
      end
    end else if (r < 95) begin
      cmd.func = FUNC_ROTATE;
    end else if (r < 97) begin
      cmd.func = FUNC_CLEAR;
    end else begin
      cmd.func = 3'($urandom_range(FuncSpareLo, FuncSpareHi));
    end
    return cmd;
  endfunction

  task automatic send_item(input logic [2:0] func, input logic [3:0] color,
                           input logic [3:0] shape);
    req_t cmd;
    int   gap;
    cmd.func  = func;
    cmd.color = color;
    cmd.shape = shape;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    start <= 1'b1;
    req_i <= cmd;
    do @(posedge clk_i); while (busy);
    expected_rsp.push_back(deque_predict(cmd));
    burst_left--;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (expected_rsp.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic test_empty_cases();
    send_item(FUNC_REMOVE, 4'h0, 4'h0);
    send_item(FUNC_ROTATE, 4'h0, 4'h0);
    send_item(FUNC_APPEND, 4'h0, 4'h0);
    send_item(FUNC_ROTATE, 4'hf, 4'hf);
    send_item(FUNC_HEAD, 4'hf, 4'hf);
    send_item(FUNC_REMOVE, 4'h5, 4'ha);
    send_item(FuncSpareLo, 4'ha, 4'h5);
    send_item(FuncSpareHi, 4'hf, 4'hf);
    send_item(FUNC_ROTATE, 4'h0, 4'h0);
  endtask

  task automatic test_full_store();
    while (shadow_count < Capacity) begin
      send_item(FUNC_APPEND, 4'($urandom), 4'($urandom));
    end
    send_item(FUNC_APPEND, 4'h3, 4'hc);
    send_item(FUNC_HEAD, 4'hc, 4'h3);
    send_item(FUNC_ROTATE, 4'h0, 4'h0);
    send_item(FUNC_REMOVE, 4'hf, 4'hf);
    send_item(FUNC_CLEAR, 4'hf, 4'hf);
  endtask

  task automatic test_random_growth(input int n);
    req_t cmd;
    repeat (n) begin
      cmd = random_command(1'b1);
      send_item(cmd.func, cmd.color, cmd.shape);
    end
  endtask

  task automatic test_random_shrink(input int n);
    req_t cmd;
    repeat (n) begin
      cmd = random_command(1'b0);
      send_item(cmd.func, cmd.color, cmd.shape);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_rsp.size() == 0) begin
        fault_count++;
        if (fault_count <= ReportLimit) begin
          $display("unexpected transfer: count %0d front %0d/%0d status %0d",
                   rsp_o.count, rsp_o.front_color, rsp_o.front_shape, rsp_o.status);
        end
      end else begin
        want_rsp = expected_rsp.pop_front();
        if (rsp_o.count !== want_rsp.count ||
            rsp_o.front_color !== want_rsp.front_color ||
            rsp_o.front_shape !== want_rsp.front_shape ||
            rsp_o.status !== want_rsp.status) begin
          fault_count++;
          if (fault_count <= ReportLimit) begin
            $display(
              "mismatch: expected count %0d front %0d/%0d status %0d, got %0d %0d/%0d %0d",
              want_rsp.count, want_rsp.front_color, want_rsp.front_shape,
              want_rsp.status, rsp_o.count, rsp_o.front_color,
              rsp_o.front_shape, rsp_o.status);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    burst_left   = 0;
    shadow_head  = 0;
    shadow_count = 0;
    foreach (shadow_store[i]) shadow_store[i] = 8'h00;
    rst_ni <= 1'b0;
    start  <= 1'b0;
    req_i  <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_cases();
    test_full_store();
    test_random_growth(300);
    wait_idle();
    test_random_shrink(300);
    wait_idle();

    if (fault_count == 0 && expected_rsp.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
